[hdl/u8u2_pkg.sv]
// ----------------------------------------------------------------------------
// u8u2_pkg
// Shared types and constants for the UTF-8 to UCS-2 stream decoder.
// ----------------------------------------------------------------------------
package u8u2_pkg;

    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int COUNT_W = 12;
    localparam int PHASE_W = 3;
    localparam int SLOTS   = 3;
    localparam int SLOT_W  = 2;

    localparam logic [COUNT_W-1:0] MAX_UNITS_RST = 12'd128;
    localparam logic [UNIT_W-1:0]  BAD_UNIT      = 16'h003F;

    // decode phases; unused codes fall back to idle
    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SKIP   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEAD2  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LEAD3A = 3'd3;
    localparam logic [PHASE_W-1:0] PH_LEAD3B = 3'd4;

    typedef struct packed {
        logic [UNIT_W-1:0]  code_unit;
        logic               last;
        logic [COUNT_W-1:0] unit_count;
    } result_t;

    // results caused by one byte, packed from slot 0 upwards
    typedef struct packed {
        logic [SLOTS-1:0][$bits(result_t)-1:0] slot;
        logic [SLOT_W-1:0]                     count;
    } bundle_t;

endpackage

[hdl/u8u2_decode.sv]
// ----------------------------------------------------------------------------
// u8u2_decode
// Input register, decode state and per-byte decode into a result bundle.
// ----------------------------------------------------------------------------
module u8u2_decode
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [11:0]                 cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    output u8u2_pkg::bundle_t           bundle,
    input  logic                        bundle_ready
);
    import u8u2_pkg::*;

    logic               in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]  byte_reg;
    logic [COUNT_W-1:0] max_units_reg;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [BYTE_W-1:0]  lead_reg, lead_next;
    logic [BYTE_W-1:0]  held_reg, held_next;
    logic [COUNT_W-1:0] units_reg, units_next;

    logic               fire;
    logic               term;
    logic               c0, c1, e0, e1;
    logic [UNIT_W-1:0]  u0, u1;
    logic [COUNT_W-1:0] w1, w2;
    logic [SLOT_W-1:0]  n;
    result_t            r0, r1, rt;

    assign fire     = in_valid_reg && bundle_ready;
    assign s_tready = !in_valid_reg || fire;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    // candidate units before the capacity check
    always_comb
    begin
        term       = (byte_reg == '0);
        c0         = 1'b0;
        c1         = 1'b0;
        u0         = BAD_UNIT;
        u1         = BAD_UNIT;
        phase_next = phase_reg;
        lead_next  = lead_reg;
        held_next  = held_reg;
        if (term)
        begin
            phase_next = PH_IDLE;
            lead_next  = '0;
            held_next  = '0;
            unique case (phase_reg)
                PH_LEAD2, PH_LEAD3A:
                begin
                    c0 = 1'b1;
                end
                PH_LEAD3B:
                begin
                    c0 = 1'b1;
                    // held byte that is no continuation is decoded on its own
                    c1 = (held_reg[7:6] != 2'b10);
                    u1 = held_reg[7] ? BAD_UNIT : {8'h00, held_reg};
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            unique case (phase_reg)
                PH_LEAD2:
                begin
                    phase_next = PH_IDLE;
                    c0         = 1'b1;
                    u0         = {5'd0, lead_reg[4:0], byte_reg[5:0]};
                end
                PH_LEAD3A:
                begin
                    held_next  = byte_reg;
                    phase_next = PH_LEAD3B;
                end
                PH_LEAD3B:
                begin
                    phase_next = PH_IDLE;
                    c0         = 1'b1;
                    u0         = {lead_reg[3:0], held_reg[5:0], byte_reg[5:0]};
                end
                default:
                begin
                    priority if (phase_reg == PH_SKIP && byte_reg[7:6] == 2'b10)
                    begin
                        phase_next = PH_SKIP;
                    end
                    else if (byte_reg[7:5] == 3'b110)
                    begin
                        lead_next  = byte_reg;
                        phase_next = PH_LEAD2;
                    end
                    else if (byte_reg[7:4] == 4'b1110)
                    begin
                        lead_next  = byte_reg;
                        phase_next = PH_LEAD3A;
                    end
                    else if (byte_reg[7])
                    begin
                        c0         = 1'b1;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        c0         = 1'b1;
                        u0         = {8'h00, byte_reg};
                        phase_next = PH_IDLE;
                    end
                end
            endcase
        end
    end

    // capacity check per unit, then pack the bundle
    always_comb
    begin
        e0 = c0 && (units_reg < max_units_reg);
        w1 = units_reg + {{(COUNT_W-1){1'b0}}, e0};
        e1 = c1 && (w1 < max_units_reg);
        w2 = w1 + {{(COUNT_W-1){1'b0}}, e1};

        r0 = '{code_unit: u0, last: 1'b0, unit_count: w1};
        r1 = '{code_unit: u1, last: 1'b0, unit_count: w2};
        rt = '{code_unit: '0, last: 1'b1, unit_count: w2};

        bundle = '0;
        n      = '0;
        if (e0)
        begin
            bundle.slot[n] = r0;
            n              = n + 2'd1;
        end
        if (e1)
        begin
            bundle.slot[n] = r1;
            n              = n + 2'd1;
        end
        if (term)
        begin
            bundle.slot[n] = rt;
            n              = n + 2'd1;
        end
        // empty bundle unless a byte is held
        bundle.count = in_valid_reg ? n : '0;

        units_next = term ? '0 : w2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            max_units_reg <= MAX_UNITS_RST;
            phase_reg     <= PH_IDLE;
            lead_reg      <= '0;
            held_reg      <= '0;
            units_reg     <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg_we)
            begin
                max_units_reg <= cfg_wdata;
            end
            if (fire)
            begin
                phase_reg <= phase_next;
                lead_reg  <= lead_next;
                held_reg  <= held_next;
                units_reg <= units_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
        end
    end

endmodule

[hdl/u8u2_serial.sv]
// ----------------------------------------------------------------------------
// u8u2_serial
// Result register: holds one bundle and hands its results out one by one.
// ----------------------------------------------------------------------------
module u8u2_serial
(
    input  logic                clk,
    input  logic                rst_n,
    input  u8u2_pkg::bundle_t   bundle,
    output logic                bundle_ready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,
    output logic                m_tlast
);
    import u8u2_pkg::*;

    logic [SLOTS-1:0][$bits(result_t)-1:0] buf_reg, buf_next;
    logic [SLOT_W-1:0]                     rem_reg, rem_next;
    logic                                  take;
    result_t                               head;

    assign head     = result_t'(buf_reg[0]);
    assign m_tvalid = (rem_reg != '0);
    assign m_tdata  = {4'd0, head.unit_count, head.code_unit};
    assign m_tlast  = head.last;
    assign take     = m_tvalid && m_tready;
    // a new bundle may load as the final result of the current one leaves
    assign bundle_ready = (rem_reg == '0) || (take && rem_reg == 2'd1);

    always_comb
    begin
        buf_next = buf_reg;
        rem_next = rem_reg;
        if (bundle_ready)
        begin
            buf_next = bundle.slot;
            rem_next = bundle.count;
        end
        else if (take)
        begin
            buf_next[0] = buf_reg[1];
            buf_next[1] = buf_reg[2];
            rem_next    = rem_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

[hdl/utf8_to_ucs2_stream_decoder.sv]
// Path: a byte is held in the input register, then its results in the result register.
// Throughput: one byte per cycle while m_tready is high and each byte gives at
//   most one result; a terminator after a cut-short lead gives up to three results,
//   one a cycle, and holds input until the last has left (single result register).
// Reset: rst_n asynchronous, active low; decode state idle, count zero,
//   max_units 128. No clearing pass.
// ----------------------------------------------------------------------------
// utf8_to_ucs2_stream_decoder
// Streaming UTF-8 byte to UCS-2 code unit decoder with a unit limit.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_stream_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [11:0] cfg_wdata,   // max_units
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] byte_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [15:0] code_unit, [27:16] unit_count
    output logic        m_tlast
);
    import u8u2_pkg::*;

    bundle_t bundle;
    logic    bundle_ready;

    u8u2_decode u_decode
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .bundle       (bundle),
        .bundle_ready (bundle_ready)
    );

    u8u2_serial u_serial
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .bundle       (bundle),
        .bundle_ready (bundle_ready),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for utf8_to_ucs2_stream_decoder: bytes go in on the
// slave stream, each one is run through a behavioural decoder kept in the
// bench, and every unit on the master stream is compared with the oldest
// predicted unit. Valid, invalid, truncated and capacity cases are directed;
// random strings follow under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;

    import u8u2_pkg::*;

    localparam int          DRAIN_CYCLES = 6;
    localparam int          HOLD_CYCLES  = 60;
    localparam logic [1:0]  CONT_TAG     = 2'b10;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [11:0]       cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;
    logic              m_tlast;

    // bench copy of the decoder state
    logic [PHASE_W-1:0] dec_phase;
    logic [BYTE_W-1:0]  dec_lead;
    logic [BYTE_W-1:0]  dec_held;
    logic [COUNT_W-1:0] dec_units;
    logic [COUNT_W-1:0] dec_max_units;

    result_t expected_units[$];
    result_t want_unit;

    int errors         = 0;
    int bytes_sent     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_seq       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    utf8_to_ucs2_stream_decoder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #1 clk = ~clk;

    initial
    begin
        #400000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic void add_unit(input logic [UNIT_W-1:0] unit);
        result_t r;
        if (dec_units >= dec_max_units)
            return;
        dec_units    = dec_units + 12'd1;
        r.code_unit  = unit;
        r.last       = 1'b0;
        r.unit_count = dec_units;
        expected_units.push_back(r);
    endfunction

    function automatic void predict_units(input logic [BYTE_W-1:0] b);
        result_t r;
        if (dec_phase > PH_LEAD3B)
            dec_phase = PH_IDLE;
        if (b == 8'h00)
        begin
            if (dec_phase == PH_LEAD2 || dec_phase == PH_LEAD3A)
                add_unit(BAD_UNIT);
            else if (dec_phase == PH_LEAD3B)
            begin
                add_unit(BAD_UNIT);
                if (dec_held[7:6] != CONT_TAG)
                    add_unit(dec_held[7] ? BAD_UNIT : {8'h00, dec_held});
            end
            r.code_unit  = '0;
            r.last       = 1'b1;
            r.unit_count = dec_units;
            expected_units.push_back(r);
            dec_phase = PH_IDLE;
            dec_lead  = '0;
            dec_held  = '0;
            dec_units = '0;
            return;
        end
        case (dec_phase)
            PH_LEAD2:
            begin
                dec_phase = PH_IDLE;
                add_unit({5'd0, dec_lead[4:0], b[5:0]});
            end
            PH_LEAD3A:
            begin
                dec_held  = b;
                dec_phase = PH_LEAD3B;
            end
            PH_LEAD3B:
            begin
                dec_phase = PH_IDLE;
                add_unit({dec_lead[3:0], dec_held[5:0], b[5:0]});
            end
            default:
            begin
                if (dec_phase == PH_SKIP && b[7:6] == CONT_TAG)
                    return;
                if (b[7:5] == 3'b110)
                begin
                    dec_lead  = b;
                    dec_phase = PH_LEAD2;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    dec_lead  = b;
                    dec_phase = PH_LEAD3A;
                end
                else if (b[7])
                begin
                    add_unit(BAD_UNIT);
                    dec_phase = PH_SKIP;
                end
                else
                begin
                    add_unit({8'h00, b});
                    dec_phase = PH_IDLE;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Receiver side and checking
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_units.size() == 0)
                report_mismatch("unit with none pending", m_tdata, 32'd0);
            else
            begin
                want_unit = expected_units.pop_front();
                if (m_tdata[15:0] != want_unit.code_unit)
                    report_mismatch("code_unit", 32'(m_tdata[15:0]),
                                    32'(want_unit.code_unit));
                if (m_tdata[27:16] != want_unit.unit_count)
                    report_mismatch("unit_count", 32'(m_tdata[27:16]),
                                    32'(want_unit.unit_count));
                if (m_tlast != want_unit.last)
                    report_mismatch("last", 32'(m_tlast), 32'(want_unit.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
        predict_units(b);
    endtask

    // sender pauses until every predicted unit is out and the pipe is empty
    task automatic wait_idle;
        s_tvalid <= 1'b0;
        while (expected_units.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_units(input logic [11:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we        <= 1'b0;
        dec_max_units  = value;
    endtask

    // mostly well-formed text, with some noise and broken sequences
    task automatic send_random_string(input int max_chars);
        int chars;
        int kind;
        chars = $urandom_range(max_chars, 1);
        repeat (chars)
        begin
            kind = $urandom_range(99);
            if (kind < 45)
                send_byte(8'($urandom_range(8'h7F, 8'h01)));
            else if (kind < 65)
            begin
                send_byte(8'hC0 | 8'($urandom_range(31)));
                send_byte(8'h80 | 8'($urandom_range(63)));
            end
            else if (kind < 85)
            begin
                send_byte(8'hE0 | 8'($urandom_range(15)));
                send_byte(8'h80 | 8'($urandom_range(63)));
                send_byte(8'h80 | 8'($urandom_range(63)));
            end
            else if (kind < 92)
                send_byte(8'($urandom_range(255, 1)));
            else
            begin
                // lead followed by arbitrary bytes
                send_byte(kind[0] ? 8'hC0 | 8'($urandom_range(31))
                                  : 8'hE0 | 8'($urandom_range(15)));
                send_byte(8'($urandom_range(255, 1)));
                if (kind[1])
                    send_byte(8'($urandom_range(255, 1)));
            end
        end
        // occasionally cut a lead short at the terminator
        kind = $urandom_range(9);
        if (kind == 0)
            send_byte(8'hC0 | 8'($urandom_range(31)));
        else if (kind == 1)
            send_byte(8'hE0 | 8'($urandom_range(15)));
        else if (kind == 2)
        begin
            send_byte(8'hE0 | 8'($urandom_range(15)));
            send_byte(8'($urandom_range(255, 1)));
        end
        send_byte(8'h00);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_valid_forms;
        logic [7:0] seq [10] = '{8'h7F, 8'hC2, 8'hA9, 8'hEF, 8'hBF, 8'hBF,
                                 8'hC0, 8'h80, 8'h01, 8'h00};
        foreach (seq[i])
            send_byte(seq[i]);
        wait_idle();
    endtask

    // bad lead gives '?', continuations after it are skipped
    task automatic test_invalid_bytes;
        logic [7:0] seq [7] = '{8'hFF, 8'h80, 8'hBF, 8'h41, 8'hF8, 8'h80, 8'h00};
        foreach (seq[i])
            send_byte(seq[i]);
        wait_idle();
    endtask

    task automatic test_truncated_leads;
        logic [7:0] seq [11] = '{8'hC3, 8'h00, 8'hE2, 8'h41, 8'h00, 8'hE2,
                                 8'hC3, 8'h00, 8'hE2, 8'h85, 8'h00};
        foreach (seq[i])
            send_byte(seq[i]);
        wait_idle();
    endtask

    task automatic test_unit_limit;
        logic [7:0] seq_two  [5] = '{8'h41, 8'h42, 8'h43, 8'hE2, 8'h00};
        logic [7:0] seq_none [4] = '{8'h41, 8'hC3, 8'hA9, 8'h00};
        write_max_units(12'd2);
        foreach (seq_two[i])
            send_byte(seq_two[i]);
        wait_idle();
        write_max_units(12'd0);
        foreach (seq_none[i])
            send_byte(seq_none[i]);
        wait_idle();
        write_max_units(12'd4095);
        send_random_string(6);
        wait_idle();
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                    input logic [11:0] limit, input int nbytes);
        int start;
        write_max_units(limit);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = bytes_sent;
        while (bytes_sent - start < nbytes)
            send_random_string(8);
        wait_idle();
    endtask

    task automatic test_random_strings;
        run_random_phase(0, 0, 12'd4095, 12);
        run_random_phase(75, 0, 12'd5, 12);
        run_random_phase(0, 75, 12'd1, 12);
        run_random_phase(13, 13, MAX_UNITS_RST, 12);
    endtask

    // receiver holds off while the sender keeps offering, so input backs up
    task automatic test_backpressure;
        int start;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_seq <= hold_seq + 1;
        start = bytes_sent;
        while (bytes_sent - start < 10)
            send_random_string(8);
        wait_idle();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;

        dec_phase     = PH_IDLE;
        dec_lead      = '0;
        dec_held      = '0;
        dec_units     = '0;
        dec_max_units = MAX_UNITS_RST;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_valid_forms();
        test_invalid_bytes();
        test_truncated_leads();
        test_unit_limit();
        test_random_strings();
        test_backpressure();

        wait_idle();
        if (expected_units.size() != 0)
            report_mismatch("units never produced", 32'd0, expected_units.size());

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
